>>> rtl/sob_pkg.sv
// sob_pkg: shared types and constants of the sine oscillator bank
// no dependencies; imported by every rtl module of the bank but sob_checker
package sob_pkg;

	localparam int unsigned CH_W       = 6;
	localparam int unsigned VAL_W      = 16;
	localparam int unsigned LEVEL_W    = 16;
	localparam int unsigned FREQ_W     = VAL_W + 1;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned RQ_DEPTH   = 16;
	localparam int unsigned RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_OFFSET = 2'd1;
	localparam logic [1:0] ACT_BASE   = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_OFFSET = 2'd1,
		CMD_BASE   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [CH_W-1:0]           channel;
		logic signed [VAL_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_head_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            last;
	} meta_t;

	typedef struct packed {
		logic                     valid;
		logic [COUNT_W-1:0]       count;
		logic signed [FREQ_W-1:0] freq;
		meta_t                    meta;
	} lev_in_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [RQ_CNT_W-1:0] fill;
		logic                done;
	} rq_stat_t;

endpackage

>>> rtl/sob_front.sv
// sob_front: request intake, classification and command queue
// depends on sob_pkg
module sob_front #(
	parameter int CHANNELS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [1:0]                            action,
	input  logic [sob_pkg::CH_W-1:0]              channel,
	input  logic signed [sob_pkg::VAL_W-1:0]      value,
	output sob_pkg::cmdq_head_t                   head,
	input  logic                                  head_pop
);
	import sob_pkg::*;

	localparam int unsigned AW = $clog2(CMDQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_range;
	logic             keep;
	cmd_t             cmd;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign in_range = ({1'b0, channel} < CH_LIMIT);

	always_comb begin
		cmd.channel = channel;
		cmd.value   = value;
		cmd.kind    = CMD_TICK;
		keep        = 1'b0;
		case (action)
			ACT_TICK: begin
				keep = 1'b1;
			end
			ACT_OFFSET: begin
				cmd.kind = CMD_OFFSET;
				keep     = in_range;
			end
			ACT_BASE: begin
				cmd.kind = CMD_BASE;
				keep     = in_range;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		keep = keep && push && !full;
	end

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_pop     = head_pop && head.valid;

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + CNT_W'(keep) - CNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/sob_back.sv
// sob_back: command sequencer, tick count, per-channel frequency stores
// depends on sob_pkg; feeds sob_level
module sob_back #(
	parameter int CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sob_pkg::cmdq_head_t  head,
	output logic                 head_pop,
	input  sob_pkg::rq_stat_t    rq,
	output sob_pkg::lev_in_t     lev
);
	import sob_pkg::*;

	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           ch_q;
	logic [COUNT_W-1:0]      count_q;
	logic [RQ_CNT_W-1:0]     inflight_q;
	logic [CHANNELS-1:0]     base_vld_q;
	logic [CHANNELS-1:0]     off_vld_q;
	logic [VAL_W-1:0]        base_mem [CHANNELS];
	logic [VAL_W-1:0]        off_mem [CHANNELS];

	logic                    credit_ok;
	logic                    issue;
	logic                    at_last;
	logic                    take;
	logic                    is_tick;
	logic                    wr_base;
	logic                    wr_off;
	logic [CW-1:0]           wr_addr;

	logic                    valid_s1;
	logic [COUNT_W-1:0]      count_s1;
	meta_t                   meta_s1;
	logic [VAL_W-1:0]        base_s1;
	logic [VAL_W-1:0]        off_s1;
	logic                    base_ok_s1;
	logic                    off_ok_s1;

	logic                    valid_s2;
	logic [COUNT_W-1:0]      count_s2;
	meta_t                   meta_s2;
	logic signed [FREQ_W-1:0] freq_s2;

	logic signed [VAL_W-1:0] base_v;
	logic signed [VAL_W-1:0] off_v;

	assign credit_ok = (({1'b0, inflight_q} + {1'b0, rq.fill}) < (RQ_CNT_W + 1)'(RQ_DEPTH));
	assign issue     = (state_q == ST_WALK) && credit_ok;
	assign at_last   = (ch_q == LAST_CH);
	assign take      = (state_q == ST_IDLE) || (issue && at_last);
	assign head_pop  = take && head.valid;
	assign is_tick   = (head.cmd.kind == CMD_TICK);
	assign wr_base   = head_pop && (head.cmd.kind == CMD_BASE);
	assign wr_off    = head_pop && (head.cmd.kind == CMD_OFFSET);
	assign wr_addr   = head.cmd.channel[CW-1:0];

	// stores: read before write in the same cycle
	always_ff @(posedge clk) begin
		if (wr_base) begin
			base_mem[wr_addr] <= head.cmd.value;
		end
		if (wr_off) begin
			off_mem[wr_addr] <= head.cmd.value;
		end
		base_s1 <= base_mem[ch_q];
		off_s1  <= off_mem[ch_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= '0;
			count_q    <= '0;
			inflight_q <= '0;
			base_vld_q <= '0;
			off_vld_q  <= '0;
			base_ok_s1 <= 1'b0;
			off_ok_s1  <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (wr_base) begin
				base_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_off) begin
				off_vld_q[wr_addr] <= 1'b1;
			end
			base_ok_s1 <= base_vld_q[ch_q];
			off_ok_s1  <= off_vld_q[ch_q];
			valid_s1   <= issue;
			valid_s2   <= valid_s1;
			inflight_q <= inflight_q + RQ_CNT_W'(issue) - RQ_CNT_W'(rq.done);

			case (state_q)
				ST_IDLE: begin
					if (head_pop && is_tick) begin
						state_q <= ST_WALK;
						ch_q    <= '0;
						count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_WALK: begin
					if (issue) begin
						if (at_last) begin
							ch_q <= '0;
							if (head_pop && is_tick) begin
								count_q <= count_q + COUNT_W'(1);
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							ch_q <= ch_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		count_s1        <= count_q;
		meta_s1.channel <= CH_W'(ch_q);
		meta_s1.last    <= at_last;
		count_s2        <= count_s1;
		meta_s2         <= meta_s1;
		freq_s2         <= FREQ_W'(base_v) + FREQ_W'(off_v);
	end

	assign base_v = base_ok_s1 ? signed'(base_s1) : '0;
	assign off_v  = off_ok_s1 ? signed'(off_s1) : '0;

	assign lev.valid = valid_s2;
	assign lev.count = count_s2;
	assign lev.freq  = freq_s2;
	assign lev.meta  = meta_s2;

endmodule

>>> rtl/sob_level.sv
// sob_level: phase multiply, table index, quadrant fold and quarter-wave table
// depends on sob_pkg; fed by sob_back, drains into sob_result_q
module sob_level #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sob_pkg::lev_in_t   lev,
	output logic               res_valid,
	output sob_pkg::result_t   res
);
	import sob_pkg::*;

	localparam logic [63:0] PHASE_K     = 64'd1146832227844;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [31:0] K_LO        = PHASE_K[31:0];
	localparam logic [8:0]  K_HI        = PHASE_K[40:32];

	localparam int unsigned M_VAL = 4 * SINE_TABLE_DEPTH;
	localparam int unsigned MW    = $clog2(M_VAL + 1);
	localparam int unsigned QHW   = 25 + MW;
	localparam int unsigned QLW   = 25 + MW;
	localparam int unsigned SW    = QHW + 1;
	localparam int unsigned IW    = $clog2(M_VAL);
	localparam int unsigned AW    = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [IW-1:0] ONE_D = IW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] TWO_D = IW'(2 * SINE_TABLE_DEPTH);
	localparam logic [AW-1:0] TOP_A = AW'(SINE_TABLE_DEPTH);

	typedef logic [15:0] wave_rom_t [0:SINE_TABLE_DEPTH];

	// quarter-wave magnitudes from a q30 taylor series to x^17
	function automatic wave_rom_t build_wave();
		wave_rom_t   w;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] m;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			term = ((term * x2) >> 30) / 64'd6;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + term;
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + term;
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + term;
			term = ((term * x2) >> 30) / 64'd210;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 64'd272;
			sum  = sum + term;
			m    = (sum + 64'd16384) >> 15;
			if (m > 64'd32767) begin
				m = 64'd32767;
			end
			w[i] = m[15:0];
		end
		return w;
	endfunction

	localparam wave_rom_t WAVE = build_wave();

	logic [7:0]         valid_q;

	logic signed [49:0] prod_s3;
	logic [63:0]        pp0_s4;
	logic [31:0]        pp1_s4;
	logic [31:0]        pp2_s4;
	logic [49:0]        frac_s5;
	logic [QHW-1:0]     qh_s6;
	logic [QLW-1:0]     ql_s6;
	logic [IW-1:0]      idx_s7;
	logic [AW-1:0]      addr_s8;
	logic               neg_s8;
	logic [15:0]        mag_s9;
	logic               neg_s9;
	logic [LEVEL_W-1:0] level_s10;
	meta_t              meta_s3;
	meta_t              meta_s4;
	meta_t              meta_s5;
	meta_t              meta_s6;
	meta_t              meta_s7;
	meta_t              meta_s8;
	meta_t              meta_s9;
	meta_t              meta_s10;

	logic [63:0]        p64;
	logic [63:0]        frac;
	logic [SW-1:0]      qsum;
	logic               q1;
	logic               q0;
	logic [IW-1:0]      t2;
	logic [IW-1:0]      r;

	assign p64  = {{14{prod_s3[49]}}, prod_s3};
	assign frac = pp0_s4 + {pp1_s4 + pp2_s4, 32'b0};
	assign qsum = SW'(qh_s6) + SW'(ql_s6 >> 25);

	always_comb begin
		q1 = (idx_s7 >= TWO_D);
		t2 = q1 ? (idx_s7 - TWO_D) : idx_s7;
		q0 = (t2 >= ONE_D);
		r  = q0 ? (t2 - ONE_D) : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[6:0], lev.valid};
		end
	end

	always_ff @(posedge clk) begin
		prod_s3   <= $signed({1'b0, lev.count}) * $signed(lev.freq);
		meta_s3   <= lev.meta;
		pp0_s4    <= 64'(p64[31:0]) * 64'(K_LO);
		pp1_s4    <= p64[31:0] * 32'(K_HI);
		pp2_s4    <= p64[63:32] * K_LO;
		meta_s4   <= meta_s3;
		frac_s5   <= frac[63:14];
		meta_s5   <= meta_s4;
		qh_s6     <= QHW'(frac_s5[49:25]) * QHW'(M_VAL);
		ql_s6     <= QLW'(frac_s5[24:0]) * QLW'(M_VAL);
		meta_s6   <= meta_s5;
		idx_s7    <= qsum[25 +: IW];
		meta_s7   <= meta_s6;
		addr_s8   <= q0 ? (TOP_A - AW'(r)) : AW'(r);
		neg_s8    <= q1;
		meta_s8   <= meta_s7;
		mag_s9    <= WAVE[addr_s8];
		neg_s9    <= neg_s8;
		meta_s9   <= meta_s8;
		level_s10 <= neg_s9 ? (16'd32768 - mag_s9) : (16'd32768 + mag_s9);
		meta_s10  <= meta_s9;
	end

	assign res_valid   = valid_q[7];
	assign res.channel = meta_s10.channel;
	assign res.level   = level_s10;
	assign res.last    = meta_s10.last;

endmodule

>>> rtl/sob_result_q.sv
// sob_result_q: result queue between the level pipeline and the output side
// depends on sob_pkg
module sob_result_q (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  sob_pkg::result_t              res,
	output sob_pkg::rq_stat_t             stat,
	output logic                          empty,
	input  logic                          pop,
	output logic [sob_pkg::CH_W-1:0]      channel_out,
	output logic [sob_pkg::LEVEL_W-1:0]   level,
	output logic                          last
);
	import sob_pkg::*;

	localparam int unsigned AW = $clog2(RQ_DEPTH);

	result_t             mem_q [RQ_DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                do_pop;
	result_t             head;

	assign empty       = (cnt_q == '0);
	assign do_pop      = pop && !empty;
	assign head        = mem_q[rd_ptr_q];
	assign channel_out = head.channel;
	assign level       = head.level;
	assign last        = head.last;
	assign stat.fill   = cnt_q;
	assign stat.done   = res_valid;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_W'(res_valid) - RQ_CNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/sine_oscillator_bank_top.sv
// sine_oscillator_bank_top: top level of the sine oscillator bank
// depends on sob_pkg, sob_front, sob_back, sob_level, sob_result_q
//
// A bank of CHANNELS sine oscillators sharing one 32-bit tick count. Requests go
// into a four-deep command queue; writes to a channel outside the bank and the
// unused action code are dropped there. A tick bumps the count and walks the
// channels, one channel a cycle while the result queue has room for the levels
// in flight, and yields CHANNELS levels in channel order, the final one marked
// by last; the single shared phase multiplier chain and quarter-wave table port
// serve all channels. Results wait in a sixteen-deep queue; when it and the
// levels in flight would fill it, the walk pauses and the command queue backs
// up into full.
module sine_oscillator_bank_top #(
	parameter int CHANNELS         = 8,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           action,
	input  logic [sob_pkg::CH_W-1:0]             channel,
	input  logic signed [sob_pkg::VAL_W-1:0]     value,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [sob_pkg::CH_W-1:0]             channel_out,
	output logic [sob_pkg::LEVEL_W-1:0]          level,
	output logic                                 last
);
	import sob_pkg::*;

	cmdq_head_t head;
	logic       head_pop;
	rq_stat_t   rq;
	lev_in_t    lev;
	logic       res_valid;
	result_t    res;

	sob_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.action   (action),
		.channel  (channel),
		.value    (value),
		.head     (head),
		.head_pop (head_pop)
	);

	sob_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_pop (head_pop),
		.rq       (rq),
		.lev      (lev)
	);

	sob_level #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.lev       (lev),
		.res_valid (res_valid),
		.res       (res)
	);

	sob_result_q u_result_q (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.stat        (rq),
		.empty       (empty),
		.pop         (pop),
		.channel_out (channel_out),
		.level       (level),
		.last        (last)
	);

endmodule

>>> rtl/sob_checker.sv
// sob_checker: port-level checks on the sine oscillator bank, bound to the top
// depends on sine_oscillator_bank_top
module sob_checker #(
	parameter int CHANNELS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [5:0]  channel_out,
	input logic [15:0] level,
	input logic        last
);

	localparam logic [5:0] LAST_CH = 6'(CHANNELS - 1);

	logic [5:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (pop && !empty) begin
			exp_q <= last ? 6'd0 : channel_out + 6'd1;
		end
	end

	// nothing to deliver while reset holds
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// levels walk the channels in order, restarting after each last
	a_channel_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |-> (channel_out == exp_q))
		else $error("result channel out of order");

	a_last_marks_top: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (channel_out == LAST_CH)))
		else $error("last flag does not match final channel");

	// offset-binary sine never reaches zero
	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (level != 16'd0))
		else $error("level out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(channel_out) && $stable(level)
			&& $stable(last)))
		else $error("waiting result changed");

endmodule

bind sine_oscillator_bank_top sob_checker #(.CHANNELS(CHANNELS)) u_sob_checker (.*);

>>> bench/tb_top.sv
// tb_top: self-checking bench for sine_oscillator_bank_top, with a bit-exact level predictor
// depends on sob_pkg and sine_oscillator_bank_top; directed then random requests in three
// idling phases, each result checked against the oldest predicted level
`timescale 1ns / 1ps

module tb_top;
	import sob_pkg::*;

	localparam int CHANNELS    = 8;
	localparam int SINE_DEPTH  = 1024;
	localparam int STALL_LIMIT = 5000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [63:0] TURN_SCALE = 64'd1146832227844;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct {
		logic [1:0]              act;
		logic [CH_W-1:0]         ch;
		logic signed [VAL_W-1:0] val;
	} osc_req_t;

	logic                        clk;
	logic                        arst_n = 1'b1;
	logic                        push = 1'b0;
	logic                        full;
	logic [1:0]                  action = ACT_TICK;
	logic [CH_W-1:0]             channel = '0;
	logic signed [VAL_W-1:0]     value = '0;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [CH_W-1:0]             channel_out;
	logic [LEVEL_W-1:0]          level;
	logic                        last;

	osc_req_t                    req_q[$];
	result_t                     level_q[$];
	int                          send_idle = 0;
	int                          recv_idle = 0;
	int                          fail_cnt = 0;
	int                          stall_cnt = 0;

	logic [15:0]                 wave_mag [0:SINE_DEPTH];
	logic [COUNT_W-1:0]          tick_cnt;
	logic signed [VAL_W-1:0]     base_tab [CHANNELS];
	logic signed [VAL_W-1:0]     offs_tab [CHANNELS];

	sine_oscillator_bank_top #(
		.CHANNELS(CHANNELS),
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.channel(channel),
		.value(value),
		.empty(empty),
		.pop(pop),
		.channel_out(channel_out),
		.level(level),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Q30 Taylor series of sin, odd terms to x^17
	function automatic logic [63:0] sine_q30(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] k;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		return acc;
	endfunction

	function automatic logic [15:0] osc_level(logic [31:0] cnt, logic signed [16:0] f);
		logic [63:0] fw;
		logic [63:0] phase;
		logic [63:0] idx;
		logic [63:0] quad;
		logic [63:0] r;
		logic [16:0] mag;
		fw = {{47{f[16]}}, f};
		phase = {32'd0, cnt} * fw * TURN_SCALE;
		idx = ((phase >> 14) * (4 * SINE_DEPTH)) >> 50;
		quad = idx / SINE_DEPTH;
		r = idx % SINE_DEPTH;
		mag = quad[0] ? wave_mag[SINE_DEPTH - r] : wave_mag[r];
		return quad[1] ? 16'(17'd32768 - mag) : 16'(17'd32768 + mag);
	endfunction

	task automatic bank_reset();
		logic [63:0] m;
		int i;
		for (i = 0; i <= SINE_DEPTH; i++) begin
			m = (sine_q30((HALF_PI_Q30 * i) / SINE_DEPTH) + 64'd16384) >> 15;
			wave_mag[i] = (m > 64'd32767) ? 16'd32767 : m[15:0];
		end
		tick_cnt = '0;
		for (i = 0; i < CHANNELS; i++) begin
			base_tab[i] = '0;
			offs_tab[i] = '0;
		end
	endtask

	// update the bank and queue the levels that a request produces
	task automatic apply_request(osc_req_t rq);
		result_t res;
		logic signed [16:0] f;
		int i;
		case (rq.act)
			ACT_OFFSET: if (rq.ch < CHANNELS) offs_tab[rq.ch] = rq.val;
			ACT_BASE:   if (rq.ch < CHANNELS) base_tab[rq.ch] = rq.val;
			ACT_TICK: begin
				tick_cnt = tick_cnt + 1;
				for (i = 0; i < CHANNELS; i++) begin
					f = base_tab[i] + offs_tab[i];
					res.channel = CH_W'(i);
					res.level = osc_level(tick_cnt, f);
					res.last = (i == CHANNELS - 1);
					level_q.push_back(res);
				end
			end
			default: ;
		endcase
	endtask

	task automatic add_req(logic [1:0] a, logic [CH_W-1:0] c, logic signed [VAL_W-1:0] v);
		osc_req_t rq;
		rq.act = a;
		rq.ch = c;
		rq.val = v;
		req_q.push_back(rq);
	endtask

	task automatic drain_all();
		while (req_q.size() != 0 || level_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= ACT_TICK;
			channel <= '0;
			value <= '0;
		end else begin
			if (push && !full)
				apply_request(req_q.pop_front());
			if (!(push && full)) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					push <= 1'b1;
					action <= req_q[0].act;
					channel <= req_q[0].ch;
					value <= req_q[0].val;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (level_q.size() == 0) begin
					$display("%0t: unexpected result channel_out %0d level %0d last %0d",
						$time, channel_out, level, last);
					fail_cnt++;
				end else begin
					if (channel_out !== level_q[0].channel) begin
						$display("%0t: channel_out expected %0d actual %0d",
							$time, level_q[0].channel, channel_out);
						fail_cnt++;
					end
					if (level !== level_q[0].level) begin
						$display("%0t: level (channel %0d) expected %0d actual %0d",
							$time, level_q[0].channel, level_q[0].level, level);
						fail_cnt++;
					end
					if (last !== level_q[0].last) begin
						$display("%0t: last (channel %0d) expected %0d actual %0d",
							$time, level_q[0].channel, level_q[0].last, last);
						fail_cnt++;
					end
					void'(level_q.pop_front());
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int i;
		int r;
		logic [1:0] a;
		logic [CH_W-1:0] c;
		logic signed [VAL_W-1:0] v;

		bank_reset();
		#1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 14;
		recv_idle = 46;
		// all stores clear: every level at mid scale
		add_req(ACT_TICK, 0, 0);
		add_req(ACT_BASE, 0, 16'sh7fff);
		add_req(ACT_OFFSET, 0, 16'sh7fff);
		add_req(ACT_BASE, 1, -16'sd32768);
		add_req(ACT_OFFSET, 1, -16'sd32768);
		add_req(ACT_BASE, 7, 16'sh0100);
		add_req(ACT_OFFSET, 7, -16'sd1);
		add_req(ACT_BASE, 2, 16'sd1);
		add_req(ACT_OFFSET, 3, 16'sh5555);
		add_req(ACT_BASE, 4, 16'shaaaa);
		// writes beyond the bank and the unused action code are dropped
		add_req(ACT_BASE, 8, 16'sd1234);
		add_req(ACT_OFFSET, 63, -16'sd1);
		add_req(ACT_UNUSED, 5, 16'sh7fff);
		add_req(ACT_UNUSED, 63, 16'shffff);
		// channel and value of a tick are ignored
		add_req(ACT_TICK, 63, -16'sd1);
		add_req(ACT_TICK, 42, 16'sh5a5a);
		add_req(ACT_BASE, 5, 16'sh4000);
		add_req(ACT_OFFSET, 6, 16'shc000);
		add_req(ACT_OFFSET, 2, 16'sh00ff);
		add_req(ACT_TICK, 0, 0);
		add_req(ACT_TICK, 0, 0);

		for (ph = 0; ph < 3; ph++) begin
			for (i = 0; i < 67; i++) begin
				r = $urandom_range(99);
				a = (r < 35) ? ACT_TICK : (r < 60) ? ACT_OFFSET :
					(r < 90) ? ACT_BASE : ACT_UNUSED;
				c = ($urandom_range(99) < 85) ? CH_W'($urandom_range(CHANNELS - 1)) :
					CH_W'($urandom_range(63));
				v = ($urandom_range(3) == 0) ? VAL_W'($urandom_range(511) - 256) :
					VAL_W'($urandom);
				add_req(a, c, v);
			end
			// hold further requests until every level so far has come back
			drain_all();
			if (ph == 0) begin
				send_idle = 46;
				recv_idle = 14;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
		end

		drain_all();
		repeat (40) @(posedge clk);
		if (fail_cnt == 0 && level_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sob_pkg.sv
rtl/sob_front.sv
rtl/sob_back.sv
rtl/sob_level.sv
rtl/sob_result_q.sv
rtl/sine_oscillator_bank_top.sv
rtl/sob_checker.sv
bench/tb_top.sv
